[design/hpm_pkg.sv]
// Shared types and constants for the projective point map.
// Used by hpm_div_pipe and homography_point_map_top; depends on nothing else.
package hpm_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int COEF_WIDTH  = 32;
   localparam int PROD_W      = COEF_WIDTH + COORD_WIDTH;
   localparam int SUM_W       = PROD_W + 1;
   localparam int MAG_W       = PROD_W;
   localparam int QB          = 33;
   localparam int FRAC_SH     = 20;
   localparam int OVF_SH      = QB - FRAC_SH;
   localparam int TRANS_SH    = 8;
   localparam int ONE_SH      = 36;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int LATENCY     = 3 + 1 + QB + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_H00 = 3'd0,
      CSR_H01 = 3'd1,
      CSR_H02 = 3'd2,
      CSR_H10 = 3'd3,
      CSR_H11 = 3'd4,
      CSR_H12 = 3'd5,
      CSR_H20 = 3'd6,
      CSR_H21 = 3'd7
   } csr_idx_type;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] in_x;
      logic signed [COORD_WIDTH-1:0] in_y;
   } hpm_req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic                          point_invalid;
      logic                          saturated;
   } hpm_rsp_type;

   // Numerators and denominator as magnitudes, with result signs.
   typedef struct packed {
      logic             inval;
      logic             neg_x;
      logic             neg_y;
      logic [MAG_W-1:0] n_x;
      logic [MAG_W-1:0] n_y;
      logic [MAG_W-1:0] d;
   } hpm_num_type;

   typedef struct packed {
      logic             inval;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic [MAG_W-1:0] n_x;
      logic [MAG_W-1:0] n_y;
      logic [MAG_W-1:0] d;
      logic [MAG_W-1:0] r_x;
      logic [MAG_W-1:0] r_y;
      logic [QB-1:0]    q_x;
      logic [QB-1:0]    q_y;
   } hpm_div_type;

   typedef struct packed {
      logic          inval;
      logic          neg_x;
      logic          neg_y;
      logic          ovf_x;
      logic          ovf_y;
      logic [QB:0]   qr_x;
      logic [QB:0]   qr_y;
   } hpm_rnd_type;

endpackage

[design/hpm_div_pipe.sv]
// Pipelined restoring divider for both mapped coordinates, one quotient bit per stage,
// followed by rounding and saturation. Depends on hpm_pkg.
module hpm_div_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 num_vld,
   input  hpm_pkg::hpm_num_type num,
   output logic                 rsp_valid,
   output hpm_pkg::hpm_rsp_type rsp_data
);
   import hpm_pkg::*;

   localparam logic [QB:0] MAXPOS = (QB+1)'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic [QB:0] MINMAG = MAXPOS + (QB+1)'(1);

   function automatic hpm_div_type div_step(input hpm_div_type cur, input logic bx,
                                            input logic by);
      hpm_div_type    nxt;
      logic [MAG_W:0] tx;
      logic [MAG_W:0] ty;
      logic [MAG_W:0] dw;
      nxt = cur;
      tx  = {cur.r_x, bx};
      ty  = {cur.r_y, by};
      dw  = {1'b0, cur.d};
      if (tx >= dw) begin
         nxt.r_x = MAG_W'(tx - dw);
         nxt.q_x = {cur.q_x[QB-2:0], 1'b1};
      end else begin
         nxt.r_x = tx[MAG_W-1:0];
         nxt.q_x = {cur.q_x[QB-2:0], 1'b0};
      end
      if (ty >= dw) begin
         nxt.r_y = MAG_W'(ty - dw);
         nxt.q_y = {cur.q_y[QB-2:0], 1'b1};
      end else begin
         nxt.r_y = ty[MAG_W-1:0];
         nxt.q_y = {cur.q_y[QB-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Returns {saturated, code}.
   function automatic logic [COORD_WIDTH:0] finish(input logic [QB:0] qr, input logic neg,
                                                   input logic ovf);
      logic                   sat;
      logic [COORD_WIDTH-1:0] mag;
      if (!neg) begin
         sat = ovf || (qr > MAXPOS);
         mag = sat ? MAXPOS[COORD_WIDTH-1:0] : qr[COORD_WIDTH-1:0];
         return {sat, mag};
      end
      sat = ovf || (qr > MINMAG);
      mag = sat ? MINMAG[COORD_WIDTH-1:0] : qr[COORD_WIDTH-1:0];
      return {sat, COORD_WIDTH'(-mag)};
   endfunction

   hpm_div_type st_ff [0:QB];
   hpm_div_type st_in [0:QB];
   logic        vld_ff [0:QB];
   logic        bx [0:QB-1];
   logic        by [0:QB-1];
   hpm_rnd_type rnd_ff, rnd_in;
   logic        rnd_vld_ff;
   hpm_rsp_type rsp_ff, rsp_in;
   logic        rsp_vld_ff;
   logic        up_x, up_y;
   logic [COORD_WIDTH:0] fin_x, fin_y;

   // Initial remainder is the numerator's top bits; overflow when the integer
   // part of the quotient needs more bits than the pipeline produces.
   always_comb begin
      st_in[0].inval = num.inval;
      st_in[0].neg_x = num.neg_x;
      st_in[0].neg_y = num.neg_y;
      st_in[0].n_x   = num.n_x;
      st_in[0].n_y   = num.n_y;
      st_in[0].d     = num.d;
      st_in[0].ovf_x = {{OVF_SH{1'b0}}, num.n_x} >= {num.d, {OVF_SH{1'b0}}};
      st_in[0].ovf_y = {{OVF_SH{1'b0}}, num.n_y} >= {num.d, {OVF_SH{1'b0}}};
      st_in[0].r_x   = num.n_x >> OVF_SH;
      st_in[0].r_y   = num.n_y >> OVF_SH;
      st_in[0].q_x   = '0;
      st_in[0].q_y   = '0;
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= st_in[0];
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= num_vld;
      end
   end

   genvar s;
   generate
      for (s = 0; s < QB; s++) begin : g_step
         localparam int B = QB - 1 - s;
         if (B >= FRAC_SH) begin : g_num_bit
            assign bx[s] = st_ff[s].n_x[B-FRAC_SH];
            assign by[s] = st_ff[s].n_y[B-FRAC_SH];
         end else begin : g_zero_bit
            assign bx[s] = 1'b0;
            assign by[s] = 1'b0;
         end
         always_comb begin
            st_in[s+1] = div_step(st_ff[s], bx[s], by[s]);
         end
         always_ff @(posedge clock) begin
            st_ff[s+1] <= st_in[s+1];
            if (reset) begin
               vld_ff[s+1] <= 1'b0;
            end else begin
               vld_ff[s+1] <= vld_ff[s];
            end
         end
      end
   endgenerate

   // Round to nearest, ties away from zero: bump when twice the remainder reaches d.
   always_comb begin
      up_x         = {st_ff[QB].r_x, 1'b0} >= {1'b0, st_ff[QB].d};
      up_y         = {st_ff[QB].r_y, 1'b0} >= {1'b0, st_ff[QB].d};
      rnd_in.inval = st_ff[QB].inval;
      rnd_in.neg_x = st_ff[QB].neg_x;
      rnd_in.neg_y = st_ff[QB].neg_y;
      rnd_in.ovf_x = st_ff[QB].ovf_x;
      rnd_in.ovf_y = st_ff[QB].ovf_y;
      rnd_in.qr_x  = {1'b0, st_ff[QB].q_x} + (QB+1)'(up_x);
      rnd_in.qr_y  = {1'b0, st_ff[QB].q_y} + (QB+1)'(up_y);
   end

   always_comb begin
      fin_x = finish(rnd_ff.qr_x, rnd_ff.neg_x, rnd_ff.ovf_x);
      fin_y = finish(rnd_ff.qr_y, rnd_ff.neg_y, rnd_ff.ovf_y);
      if (rnd_ff.inval) begin
         rsp_in.out_x         = '0;
         rsp_in.out_y         = '0;
         rsp_in.point_invalid = 1'b1;
         rsp_in.saturated     = 1'b0;
      end else begin
         rsp_in.out_x         = fin_x[COORD_WIDTH-1:0];
         rsp_in.out_y         = fin_y[COORD_WIDTH-1:0];
         rsp_in.point_invalid = 1'b0;
         rsp_in.saturated     = fin_x[COORD_WIDTH] | fin_y[COORD_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         rnd_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rnd_vld_ff <= vld_ff[QB];
         rsp_vld_ff <= rnd_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_final_rem_below_d: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB] && !st_ff[QB].inval && !st_ff[QB].ovf_x |-> st_ff[QB].r_x < st_ff[QB].d)
      else $error("x remainder not below divisor after last step");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.point_invalid |->
         rsp_ff.out_x == '0 && rsp_ff.out_y == '0 && !rsp_ff.saturated)
      else $error("invalid point carries nonzero result");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.saturated |->
         rsp_ff.out_x == MAXPOS[COORD_WIDTH-1:0] || rsp_ff.out_x == MINMAG[COORD_WIDTH-1:0] ||
         rsp_ff.out_y == MAXPOS[COORD_WIDTH-1:0] || rsp_ff.out_y == MINMAG[COORD_WIDTH-1:0])
      else $error("saturated result without a clipped coordinate");

endmodule

[design/homography_point_map_top.sv]
// Top level of the projective point map: coefficient registers, products, sums and
// magnitudes, then the divider pipeline. Depends on hpm_pkg and hpm_div_pipe.
//
// Usage: write the eight coefficients on the csr_ port (csr_we, csr_index, csr_wdata),
// one register per cycle, while no point is in flight. A point is taken at each
// rising edge where start is high and busy is low; busy is high only during reset,
// so a point may enter in every cycle.
// Each point gives one result beat on rsp_data, marked by rsp_valid for one cycle,
// after the point passes three stages of multiply, sum and magnitude, one overflow
// check, 33 divider stages (one quotient bit each), one rounding stage and one
// saturation stage. Throughput is one point per cycle.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Reset clears all valid bits, so nothing in flight survives, and loads the identity
// matrix. A zero denominator gives point_invalid with zero coordinates.
module homography_point_map_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  hpm_pkg::hpm_req_type                 req_data,
   input  logic                                 csr_we,
   input  logic [hpm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hpm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                 rsp_valid,
   output hpm_pkg::hpm_rsp_type                 rsp_data
);
   import hpm_pkg::*;

   localparam coef_type ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [SUM_W-1:0] T_ONE = SUM_W'(65'd1 << ONE_SH);

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] nv;
      nv = -v;
      return v[SUM_W-1] ? nv[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   coef_type coef_ff [0:7];

   logic signed [PROD_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff, pta_ff, ptb_ff;
   logic signed [PROD_W-1:0] pxa_in, pxb_in, pya_in, pyb_in, pta_in, ptb_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff, sum_t_ff;
   logic signed [SUM_W-1:0]  sum_x_in, sum_y_in, sum_t_in;
   hpm_num_type              num_ff, num_in;
   logic                     v1_ff, v2_ff, v3_ff;
   logic                     accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_H00] <= ONE_Q16;
         coef_ff[CSR_H01] <= '0;
         coef_ff[CSR_H02] <= '0;
         coef_ff[CSR_H10] <= '0;
         coef_ff[CSR_H11] <= ONE_Q16;
         coef_ff[CSR_H12] <= '0;
         coef_ff[CSR_H20] <= '0;
         coef_ff[CSR_H21] <= '0;
      end else if (csr_we) begin
         coef_ff[csr_index] <= coef_type'(csr_wdata);
      end
   end

   always_comb begin
      pxa_in = PROD_W'(coef_ff[CSR_H00]) * PROD_W'(req_data.in_x);
      pxb_in = PROD_W'(coef_ff[CSR_H01]) * PROD_W'(req_data.in_y);
      pya_in = PROD_W'(coef_ff[CSR_H10]) * PROD_W'(req_data.in_x);
      pyb_in = PROD_W'(coef_ff[CSR_H11]) * PROD_W'(req_data.in_y);
      pta_in = PROD_W'(coef_ff[CSR_H20]) * PROD_W'(req_data.in_x);
      ptb_in = PROD_W'(coef_ff[CSR_H21]) * PROD_W'(req_data.in_y);
   end

   // Translations move from 16 to 24 fraction bits; the unit term sits at 2^36.
   always_comb begin
      sum_x_in = SUM_W'(pxa_ff) + SUM_W'(pxb_ff) + (SUM_W'(coef_ff[CSR_H02]) <<< TRANS_SH);
      sum_y_in = SUM_W'(pya_ff) + SUM_W'(pyb_ff) + (SUM_W'(coef_ff[CSR_H12]) <<< TRANS_SH);
      sum_t_in = SUM_W'(pta_ff) + SUM_W'(ptb_ff) + T_ONE;
   end

   always_comb begin
      num_in.n_x   = mag_of(sum_x_ff);
      num_in.n_y   = mag_of(sum_y_ff);
      num_in.d     = mag_of(sum_t_ff);
      num_in.inval = (sum_t_ff == '0);
      num_in.neg_x = (sum_x_ff[SUM_W-1] != sum_t_ff[SUM_W-1]) && (num_in.n_x != '0);
      num_in.neg_y = (sum_y_ff[SUM_W-1] != sum_t_ff[SUM_W-1]) && (num_in.n_y != '0);
   end

   always_ff @(posedge clock) begin
      pxa_ff   <= pxa_in;
      pxb_ff   <= pxb_in;
      pya_ff   <= pya_in;
      pyb_ff   <= pyb_in;
      pta_ff   <= pta_in;
      ptb_ff   <= ptb_in;
      sum_x_ff <= sum_x_in;
      sum_y_ff <= sum_y_in;
      sum_t_ff <= sum_t_in;
      num_ff   <= num_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   hpm_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .num_vld   (v3_ff),
      .num       (num_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result beat without a point taken at the pipeline depth");

   a_no_beat_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_stage_in_order: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(accept, 3))
      else $error("front stages lost or invented a point");

endmodule
